### hdl/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types and constants for the priority play queue
// Request and result payloads, command codes, status codes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned NumQueues  = 3;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_PLAY   = 3'd1,
    KIND_SKIP   = 3'd2,
    KIND_REPLAY = 3'd3,
    KIND_REMOVE = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_ADDED     = 4'd0,
    ST_PLAYING   = 4'd1,
    ST_EMPTY     = 4'd2,
    ST_SKIPPED   = 4'd3,
    ST_FINISHED  = 4'd4,
    ST_REPLAYING = 4'd5,
    ST_REMOVED   = 4'd6,
    ST_NOT_FOUND = 4'd7,
    ST_FULL      = 4'd8,
    ST_NO_HIST   = 4'd9
  } status_e;

  localparam logic [1:0] PrefHigh   = 2'd1;
  localparam logic [1:0] PrefMiddle = 2'd2;

  typedef enum logic [1:0] {
    Q_HIGH = 2'd0,
    Q_MID  = 2'd1,
    Q_LOW  = 2'd2
  } qsel_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] song_id;
    logic [1:0]  preference;
    logic [15:0] duration;
    logic [15:0] skip_amount;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] out_song_id;
    logic [15:0] out_duration;
    logic [1:0]  served_level;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_SWEEP,
    S_NEXTQ,
    S_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic  load_req;   // capture the request
    logic  exec;       // do add/skip/replay, or pick queue for play
    logic  rd_head;    // issue a memory read at the selected queue head
    logic  pop_done;   // finish play with the registered read data
    logic  del_start;  // start removal with a read at the high queue head
    logic  del_step;   // process one registered entry of the sweep
    logic  del_end;    // commit the compacted queue
    logic  next_q;     // move the removal to the next queue
    logic  out_load;   // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic play_hit;    // some queue is non-empty for play
    logic del_last;    // sweep has reached the last entry
    logic del_empty;   // selected queue is empty
    logic last_q;      // removal is on the low queue
  } sts_t;

endpackage

### hdl/tlpq_ctrl.sv
// ----------------------------------------------------------------------------
// tlpq_ctrl: sequencing controller
// Steps each request through capture, execution, the memory read of a play
// and the entry-by-entry compaction of a remove, then holds the result.
// ----------------------------------------------------------------------------
module tlpq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [2:0]       req_kind_i,
  output logic             req_stall_o,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  input  tlpq_pkg::sts_t   sts_i,
  output tlpq_pkg::cmd_t   cmd_o
);
  import tlpq_pkg::*;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   [2:0] kind_q;
  logic   accept;

  assign accept      = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall_i);
  assign rsp_valid_o = rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      kind_q      <= 3'd0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (accept) kind_q <= req_kind_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_kind_i <= 3'(KIND_REMOVE)) state_d = S_READ;
      end
      S_READ: begin
        if (kind_q == 3'(KIND_PLAY)) state_d = sts_i.play_hit ? S_WAIT : S_RESULT;
        else if (kind_q == 3'(KIND_REMOVE)) state_d = S_WAIT;
        else state_d = S_RESULT;
      end
      S_WAIT: begin
        if (kind_q == 3'(KIND_PLAY)) state_d = S_RESULT;
        else state_d = (sts_i.del_empty || sts_i.del_last) ? S_NEXTQ : S_SWEEP;
      end
      S_SWEEP: begin
        if (sts_i.del_last) state_d = S_NEXTQ;
      end
      S_NEXTQ: begin
        state_d = sts_i.last_q ? S_RESULT : S_WAIT;
      end
      S_RESULT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    unique case (state_q)
      S_IDLE:  cmd_o.load_req = accept;
      S_READ: begin
        cmd_o.exec = 1'b1;
        if (kind_q == 3'(KIND_PLAY) && sts_i.play_hit) cmd_o.rd_head = 1'b1;
        if (kind_q == 3'(KIND_REMOVE)) cmd_o.del_start = 1'b1;
      end
      S_WAIT: begin
        if (kind_q == 3'(KIND_PLAY)) cmd_o.pop_done = 1'b1;
        else if (sts_i.del_empty) cmd_o.del_end = 1'b1;
        else begin
          cmd_o.del_step = 1'b1;
          // single-entry queue: the first step is also the last
          if (sts_i.del_last) cmd_o.del_end = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd_o.del_step = 1'b1;
        if (sts_i.del_last) cmd_o.del_end = 1'b1;
      end
      S_NEXTQ: cmd_o.next_q = 1'b1;
      S_RESULT: begin
        cmd_o.out_load = 1'b1;
        rsp_valid_d    = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hdl/tlpq_dp.sv
// ----------------------------------------------------------------------------
// tlpq_dp: queue storage and datapath
// Three circular buffers in one memory, head/count per queue, current and
// last-played entries, and the result register. Remove reads each entry in
// order and rewrites survivors at a trailing write pointer.
// ----------------------------------------------------------------------------
module tlpq_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlpq_pkg::req_t   req_i,
  input  tlpq_pkg::cmd_t   cmd_i,
  output tlpq_pkg::sts_t   sts_o,
  output tlpq_pkg::rsp_t   rsp_o
);
  import tlpq_pkg::*;

  localparam int unsigned AddrW = PtrW + 2;

  logic [31:0]     mem [NumQueues*QueueDepth];
  logic [31:0]     rd_q;

  logic [PtrW-1:0] head_q  [NumQueues];
  logic [CntW-1:0] count_q [NumQueues];

  req_t            req_q;
  logic [15:0]     cur_id_q, cur_dur_q, last_id_q, last_dur_q;
  logic            last_valid_q;
  rsp_t            res_q, rsp_o_q;
  rsp_t            exec_res;
  logic [1:0]      sel_q;

  // removal sweep
  logic [CntW-1:0] n_q, rd_i_q, keep_q;
  logic            hit_q;

  logic [1:0]      add_q, play_q;
  logic            any_hit;
  logic            rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [31:0]     wr_data;
  logic [PtrW-1:0] rd_pos, wr_pos;
  logic [CntW-1:0] nxt_i;

  always_comb begin
    if (req_q.preference == PrefHigh) add_q = 2'(Q_HIGH);
    else if (req_q.preference == PrefMiddle) add_q = 2'(Q_MID);
    else add_q = 2'(Q_LOW);
    if (count_q[0] != '0) play_q = 2'(Q_HIGH);
    else if (count_q[1] != '0) play_q = 2'(Q_MID);
    else play_q = 2'(Q_LOW);
  end

  assign any_hit = (count_q[0] != '0) || (count_q[1] != '0) || (count_q[2] != '0);

  function automatic logic [PtrW-1:0] wrap(input logic [PtrW-1:0] h,
                                           input logic [CntW-1:0] o);
    logic [CntW:0] s;
    s = {{(CntW+1-PtrW){1'b0}}, h} + {1'b0, o};
    if (s >= (CntW+1)'(QueueDepth)) s = s - (CntW+1)'(QueueDepth);
    return s[PtrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] addr(input logic [1:0] q,
                                            input logic [PtrW-1:0] p);
    return AddrW'(q) * AddrW'(QueueDepth) + AddrW'(p);
  endfunction

  assign nxt_i = rd_i_q + CntW'(1);

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_pos  = head_q[sel_q];
    wr_en   = 1'b0;
    wr_pos  = wrap(head_q[sel_q], keep_q);
    wr_data = rd_q;
    if (cmd_i.exec && req_q.kind == 3'(KIND_ADD) && count_q[add_q] < CntW'(QueueDepth)) begin
      wr_en   = 1'b1;
      wr_pos  = wrap(head_q[add_q], count_q[add_q]);
      wr_data = {req_q.song_id, req_q.duration};
    end
    if (cmd_i.rd_head) begin
      rd_en  = 1'b1;
      rd_pos = head_q[play_q];
    end
    if (cmd_i.del_start) begin
      rd_en  = 1'b1;
      rd_pos = head_q[Q_HIGH];
    end
    if (cmd_i.del_step) begin
      rd_en  = 1'b1;
      rd_pos = wrap(head_q[sel_q], nxt_i);
      wr_en  = (rd_q[31:16] != req_q.song_id);
    end
    if (cmd_i.next_q) begin
      rd_en  = (sel_q != 2'(Q_LOW));
      rd_pos = head_q[sel_q + 2'd1 > 2'(Q_LOW) ? sel_q : sel_q + 2'd1];
    end
  end

  always_comb begin
    rd_addr = addr(cmd_i.rd_head ? play_q :
                   cmd_i.del_start ? 2'(Q_HIGH) :
                   cmd_i.next_q ? sel_q + 2'd1 : sel_q, rd_pos);
    wr_addr = addr(cmd_i.exec && req_q.kind == 3'(KIND_ADD) ? add_q : sel_q, wr_pos);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  // result of the execute step
  always_comb begin
    exec_res = '0;
    unique case (req_q.kind)
      3'(KIND_ADD): begin
        exec_res.status = (count_q[add_q] < CntW'(QueueDepth)) ? ST_ADDED : ST_FULL;
      end
      3'(KIND_PLAY): begin
        exec_res.status = any_hit ? ST_PLAYING : ST_EMPTY;
      end
      3'(KIND_SKIP): begin
        exec_res.out_song_id = cur_id_q;
        if (cur_dur_q > req_q.skip_amount) begin
          exec_res.status       = ST_SKIPPED;
          exec_res.out_duration = cur_dur_q - req_q.skip_amount;
        end else begin
          exec_res.status       = ST_FINISHED;
          exec_res.out_duration = cur_dur_q;
        end
      end
      3'(KIND_REPLAY): begin
        if (last_valid_q) begin
          exec_res.status       = ST_REPLAYING;
          exec_res.out_song_id  = last_id_q;
          exec_res.out_duration = last_dur_q;
        end else begin
          exec_res.status = ST_NO_HIST;
        end
      end
      default: exec_res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NumQueues; q++) begin
        head_q[q]  <= '0;
        count_q[q] <= '0;
      end
      cur_id_q     <= '0;
      cur_dur_q    <= '0;
      last_id_q    <= '0;
      last_dur_q   <= '0;
      last_valid_q <= 1'b0;
      res_q        <= '0;
      rsp_o_q      <= '0;
      sel_q        <= '0;
      n_q          <= '0;
      rd_i_q       <= '0;
      keep_q       <= '0;
      hit_q        <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        res_q <= exec_res;
        unique case (req_q.kind)
          3'(KIND_ADD): begin
            if (count_q[add_q] < CntW'(QueueDepth))
              count_q[add_q] <= count_q[add_q] + CntW'(1);
          end
          3'(KIND_PLAY): begin
            sel_q <= play_q;
          end
          3'(KIND_SKIP): begin
            if (cur_dur_q > req_q.skip_amount)
              cur_dur_q <= cur_dur_q - req_q.skip_amount;
          end
          3'(KIND_REPLAY): begin
            if (last_valid_q) begin
              cur_id_q  <= last_id_q;
              cur_dur_q <= last_dur_q;
            end
          end
          default: begin
            sel_q  <= 2'(Q_HIGH);
            n_q    <= count_q[0];
            rd_i_q <= '0;
            keep_q <= '0;
            hit_q  <= 1'b0;
          end
        endcase
      end
      if (cmd_i.pop_done) begin
        cur_id_q       <= rd_q[31:16];
        cur_dur_q      <= rd_q[15:0];
        last_id_q      <= rd_q[31:16];
        last_dur_q     <= rd_q[15:0];
        last_valid_q   <= 1'b1;
        res_q          <= {res_q.status, rd_q, sel_q + 2'd1};
        head_q[sel_q]  <= wrap(head_q[sel_q], CntW'(1));
        count_q[sel_q] <= count_q[sel_q] - CntW'(1);
      end
      if (cmd_i.del_step) begin
        rd_i_q <= nxt_i;
        if (rd_q[31:16] != req_q.song_id) keep_q <= keep_q + CntW'(1);
        else hit_q <= 1'b1;
      end
      if (cmd_i.del_end) begin
        // survivors were rewritten from the head on; commit the new fill
        count_q[sel_q] <= (cmd_i.del_step && rd_q[31:16] != req_q.song_id)
                          ? keep_q + CntW'(1) : keep_q;
      end
      if (cmd_i.next_q) begin
        if (sel_q != 2'(Q_LOW)) begin
          sel_q <= sel_q + 2'd1;
          n_q   <= count_q[sel_q + 2'd1 > 2'(Q_LOW) ? sel_q : sel_q + 2'd1];
        end
        rd_i_q <= '0;
        keep_q <= '0;
      end
      if (cmd_i.out_load) begin
        rsp_o_q <= (req_q.kind == 3'(KIND_REMOVE))
                   ? {(hit_q ? ST_REMOVED : ST_NOT_FOUND), 34'd0} : res_q;
      end
    end
  end

  assign sts_o.play_hit  = any_hit;
  assign sts_o.del_last  = (nxt_i == n_q);
  assign sts_o.del_empty = (n_q == '0);
  assign sts_o.last_q    = (sel_q == 2'(Q_LOW));
  assign rsp_o           = rsp_o_q;

endmodule

### hdl/three_level_priority_play_queue.sv
// ----------------------------------------------------------------------------
// three_level_priority_play_queue: strict-priority play queue
//
//   channel  | valid       | stall       | payload
//   request  | req_valid_i | req_stall_o | req_i  (tlpq_pkg::req_t)
//   result   | rsp_valid_o | rsp_stall_i | rsp_o  (tlpq_pkg::rsp_t)
//
// Add, skip, replay and an empty play pass through capture, execute and
// result; a play that finds an entry adds a wait for the registered queue memory read.
// Remove sweeps each queue in turn from its head, one entry of the shared
// memory port per cycle, and rewrites the survivors in place.
// Reset empties all queues at once through head/count registers.
// A waiting result blocks only the next request's acceptance.
// ----------------------------------------------------------------------------
module three_level_priority_play_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  tlpq_pkg::req_t   req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  output tlpq_pkg::rsp_t   rsp_o
);
  import tlpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_kind_i  (req_i.kind),
    .req_stall_o (req_stall_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlpq_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.exec && cmd.out_load)) else $error("exec and result load overlap");

  a_rsp_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> rsp_valid_o) else $error("result not presented");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del_step |-> req_stall_o) else $error("request taken during remove");

endmodule
